// ===== design/smh_pkg.sv =====
// Shared types and constants for the SHA-256 message hasher.
// Holds the round constant table, the initial chaining value and the
// control/status structs between the sequencer and the compression core.
package smh_pkg;

  localparam int unsigned SMH_WORD_W   = 32;
  localparam int unsigned SMH_ROUNDS   = 64;
  localparam int unsigned SMH_BLOCK_W  = 512;
  localparam logic [7:0]  SMH_PAD_BYTE = 8'h80;
  localparam logic [5:0]  SMH_LEN_POS  = 6'd56;

  // Initial chaining value, H0 in entry 0
  localparam logic [7:0][31:0] SMH_IV = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [31:0] SMH_K [SMH_ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Sequencer to core
  typedef struct packed {
    logic       push;    // shift one byte into the block window
    logic [7:0] data;    // byte to shift in
    logic       start;   // begin compressing the window
    logic       init;    // reload the initial chaining value
  } smh_ctl_t;

  // Core to sequencer
  typedef struct packed {
    logic             busy;
    logic [7:0][31:0] hash;
  } smh_stat_t;

endpackage

// ===== design/smh_core.sv =====
// SHA-256 compression core: 512-bit block window that doubles as the
// message schedule, one round per cycle, then a chaining add step.
// Depends on smh_pkg.
module smh_core
  import smh_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  smh_ctl_t  ctl,
  output smh_stat_t stat
);

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_ROUND = 2'd1;
  localparam logic [1:0] PH_ADD   = 2'd2;

  logic [1:0]             ph_r, ph_nxt;
  logic [5:0]             rnd_r, rnd_nxt;
  logic [SMH_BLOCK_W-1:0] win_r, win_nxt;
  logic [7:0][31:0]       v_r, v_nxt;
  logic [7:0][31:0]       hash_r, hash_nxt;

  logic [31:0] w0, w1, w9, w14, w_new;
  logic [31:0] t1, t2, big0, big1, chs, mj;

  function automatic logic [31:0] rotr(input logic [31:0] x, input logic [4:0] n);
    rotr = (x >> n) | (x << (6'd32 - {1'b0, n}));
  endfunction

  // Schedule window taps: word i sits at bits [511-32i -: 32]
  assign w0  = win_r[511:480];
  assign w1  = win_r[479:448];
  assign w9  = win_r[223:192];
  assign w14 = win_r[63:32];

  assign w_new = (rotr(w14, 5'd17) ^ rotr(w14, 5'd19) ^ (w14 >> 10)) + w9
               + (rotr(w1, 5'd7) ^ rotr(w1, 5'd18) ^ (w1 >> 3)) + w0;

  assign big1 = rotr(v_r[4], 5'd6) ^ rotr(v_r[4], 5'd11) ^ rotr(v_r[4], 5'd25);
  assign chs  = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
  assign t1   = v_r[7] + big1 + chs + SMH_K[rnd_r] + w0;
  assign big0 = rotr(v_r[0], 5'd2) ^ rotr(v_r[0], 5'd13) ^ rotr(v_r[0], 5'd22);
  assign mj   = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
  assign t2   = big0 + mj;

  always_comb begin
    ph_nxt   = ph_r;
    rnd_nxt  = rnd_r;
    win_nxt  = win_r;
    v_nxt    = v_r;
    hash_nxt = hash_r;
    unique case (ph_r)
      PH_ROUND: begin
        v_nxt   = {v_r[6], v_r[5], v_r[4], v_r[3] + t1, v_r[2], v_r[1], v_r[0], t1 + t2};
        win_nxt = {win_r[SMH_BLOCK_W-SMH_WORD_W-1:0], w_new};
        rnd_nxt = rnd_r + 6'd1;
        if (rnd_r == 6'(SMH_ROUNDS - 1)) begin
          ph_nxt = PH_ADD;
        end
      end
      PH_ADD: begin
        for (int i = 0; i < 8; i++) begin
          hash_nxt[i] = hash_r[i] + v_r[i];
        end
        ph_nxt = PH_IDLE;
      end
      default: begin
        if (ctl.init) begin
          hash_nxt = SMH_IV;
        end
        if (ctl.push) begin
          win_nxt = {win_r[SMH_BLOCK_W-9:0], ctl.data};
        end
        if (ctl.start) begin
          v_nxt   = hash_r;
          rnd_nxt = '0;
          ph_nxt  = PH_ROUND;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= PH_IDLE;
      rnd_r  <= '0;
      hash_r <= SMH_IV;
    end else begin
      ph_r   <= ph_nxt;
      rnd_r  <= rnd_nxt;
      hash_r <= hash_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
    v_r   <= v_nxt;
  end

  assign stat.busy = (ph_r != PH_IDLE);
  assign stat.hash = hash_r;

endmodule

// ===== design/sha256_message_hasher_unit.sv =====
// SHA-256 message hasher top level: byte stream in, four 64-bit digest
// words out. Sequencer for load, padding and output around smh_core.
// Depends on smh_pkg and smh_core.
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+-----------------------------------------
//  in_     | in  | in_tvalid / in_tready | tdata[7:0]=data_byte, tuser=byte_present,
//          |     |                       | tlast=end_of_message
//  out_    | out | out_tvalid/out_tready | tdata[63:0]=digest_word,
//          |     |                       | tuser[1:0]=word_index, tlast=last_word
//
// Every 64th byte starts a compression: 64 rounds at one per cycle, a
// chaining add and a step for the sequencer to see the core idle, all with
// in_tready low; the single round unit in smh_core sets the round rate.
// The end-of-message transfer feeds padding bytes one per cycle up to the
// end of the block (at most 64 bytes, or 72 with an extra block), with a
// compression after each padded block, then presents four digest
// words. in_tready is low from padding until the last word is taken.
// Reset is synchronous and active low; the chaining value returns to the
// initial hash value after reset and after every digest. A stall on
// out_tready holds the current digest word.
module sha256_message_hasher_unit
  import smh_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] byte_present
  input  logic        in_tlast,   // end_of_message
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [63:0] digest_word
  output logic [1:0]  out_tuser,  // [1:0] word_index
  output logic        out_tlast   // last_word
);

  localparam logic [2:0] ST_IDLE  = 3'd0;  // take message bytes
  localparam logic [2:0] ST_COMP  = 3'd1;  // compress a full message block
  localparam logic [2:0] ST_PAD   = 3'd2;  // feed padding bytes
  localparam logic [2:0] ST_PCOMP = 3'd3;  // compress a padded block
  localparam logic [2:0] ST_OUT   = 3'd4;  // present digest words

  logic [2:0]  st_r, st_nxt;
  logic [5:0]  fill_r, fill_nxt;
  logic [63:0] bits_r, bits_nxt;
  logic        eom_r, eom_nxt;
  logic        first_r, first_nxt;
  logic        len_r, len_nxt;
  logic [1:0]  widx_r, widx_nxt;

  smh_ctl_t    ctl;
  smh_stat_t   stat;

  logic        len_act;
  logic [63:0] len_sh;

  smh_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .stat  (stat)
  );

  // Length bytes go out big-endian once the fill count reaches the length slot
  assign len_act = !first_r && (len_r || (fill_r == SMH_LEN_POS));
  assign len_sh  = bits_r >> {~fill_r[2:0], 3'b000};

  always_comb begin
    st_nxt    = st_r;
    fill_nxt  = fill_r;
    bits_nxt  = bits_r;
    eom_nxt   = eom_r;
    first_nxt = first_r;
    len_nxt   = len_r;
    widx_nxt  = widx_r;
    ctl       = '0;
    unique case (st_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser) begin
            // append the byte; a full block goes to compression first
            ctl.push = 1'b1;
            ctl.data = in_tdata;
            bits_nxt = bits_r + 64'd8;
            fill_nxt = fill_r + 6'd1;
            if (fill_r == 6'd63) begin
              ctl.start = 1'b1;
              eom_nxt   = in_tlast;
              st_nxt    = ST_COMP;
            end else if (in_tlast) begin
              st_nxt = ST_PAD;
            end
          end else if (in_tlast) begin
            st_nxt = ST_PAD;
          end
          first_nxt = 1'b1;
          len_nxt   = 1'b0;
        end
      end
      ST_COMP: begin
        if (!stat.busy) begin
          st_nxt = eom_r ? ST_PAD : ST_IDLE;
        end
      end
      ST_PAD: begin
        ctl.push = 1'b1;
        priority if (first_r) begin
          ctl.data = SMH_PAD_BYTE;
        end else if (len_act) begin
          ctl.data = len_sh[7:0];
        end else begin
          ctl.data = 8'h00;
        end
        first_nxt = 1'b0;
        if (len_act) begin
          len_nxt = 1'b1;
        end
        fill_nxt = fill_r + 6'd1;
        if (fill_r == 6'd63) begin
          ctl.start = 1'b1;
          st_nxt    = ST_PCOMP;
        end
      end
      ST_PCOMP: begin
        if (!stat.busy) begin
          st_nxt   = len_r ? ST_OUT : ST_PAD;
          widx_nxt = '0;
        end
      end
      ST_OUT: begin
        if (out_tready) begin
          widx_nxt = widx_r + 2'd1;
          if (widx_r == 2'd3) begin
            // back to the start state for the next message
            ctl.init = 1'b1;
            bits_nxt = '0;
            fill_nxt = '0;
            eom_nxt  = 1'b0;
            st_nxt   = ST_IDLE;
          end
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_IDLE;
      fill_r  <= '0;
      bits_r  <= '0;
      eom_r   <= 1'b0;
      first_r <= 1'b0;
      len_r   <= 1'b0;
      widx_r  <= '0;
    end else begin
      st_r    <= st_nxt;
      fill_r  <= fill_nxt;
      bits_r  <= bits_nxt;
      eom_r   <= eom_nxt;
      first_r <= first_nxt;
      len_r   <= len_nxt;
      widx_r  <= widx_nxt;
    end
  end

  assign in_tready  = (st_r == ST_IDLE);
  assign out_tvalid = (st_r == ST_OUT);
  assign out_tdata  = {stat.hash[{widx_r, 1'b0}], stat.hash[{widx_r, 1'b1}]};
  assign out_tuser  = widx_r;
  assign out_tlast  = (widx_r == 2'd3);

`ifndef SYNTH
  // digest words only show once the last compression has finished
  a_out_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !stat.busy)
    else $error("digest presented while compression runs");

  // padding always ends on a block boundary
  a_out_fill_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (fill_r == 6'd0))
    else $error("fill count not zero at digest output");

  // a compression is never started on top of a running one
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start |-> !stat.busy)
    else $error("compression started while busy");

  // after the final word the block is ready for the next message
  a_ready_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> (in_tready && !stat.busy))
    else $error("not ready after last digest word");
`endif

endmodule
